// ===== src/bfwa_pkg.sv =====
// shared types and constants for the bounded fifo window average block
`default_nettype none

package bfwa_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = 7;
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 30;
    localparam int CMD_W      = 2;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [CNT_W-1:0] MAX_SIZE_RESET = 7'd65;
    localparam logic [CNT_W-1:0] MAX_SIZE_MIN   = 7'd2;
    localparam logic [CNT_W-1:0] MAX_SIZE_MAX   = CNT_W'(RING_DEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] head_value;
        logic                       head_valid;
        logic [CNT_W-1:0]           count;
        logic signed [SAMPLE_W-1:0] average;
        logic                       average_valid;
    } t_out_res;

endpackage

`default_nettype wire

// ===== src/bounded_fifo_window_average_core.sv =====
// bounded fifo of q15.8 samples with running window average
//
// Usage: requests enter on i_in_valid/o_in_ready with i_in_req (push,
// pop or peek). Each request yields exactly one result on
// o_out_valid/i_out_ready: oldest sample (the removed one for pop), the
// sample count after the request and the window average, truncated
// toward zero. The fifo holds at most max_size-1 samples (max_size is
// clamped to 2..65); a push into a full fifo drops the oldest sample.
// The user must see that max_size is written through
// i_cfg_valid/i_cfg_data only while idle; the block does not enforce it.
// Sequence: one request at a time; a read-modify-write of the sample
// ring (read, wait and load states), then a bit-serial restoring
// divider for the average (one quotient bit per cycle), then the output
// load. A request that leaves the fifo empty skips the divider.
// The result sits in an output register, so the next request is
// accepted while it waits; if the receiver stalls, the following request
// finishes and waits until the output register is free. Reset empties
// the fifo and sets max_size to 65; the ring contents are not cleared.
`default_nettype none

module bounded_fifo_window_average_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire bfwa_pkg::t_in_req          i_in_req,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output bfwa_pkg::t_out_res              o_out_res,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bfwa_pkg::CNT_W-1:0] i_cfg_data
);

    import bfwa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_WAIT = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]           r_max;
    logic [PTR_W-1:0]           r_ptr, n_ptr;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    t_in_req                    r_req;
    logic signed [SAMPLE_W-1:0] r_head, n_head;
    logic                       r_head_ok, n_head_ok;
    logic [SUM_W-1:0]           r_quo, n_quo;
    logic [CNT_W-1:0]           r_rem, n_rem;
    logic                       r_neg, n_neg;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_out_valid;
    t_out_res                   r_out;

    logic                       mem_we;
    logic [PTR_W-1:0]           mem_waddr;
    logic [SAMPLE_W-1:0]        mem_rdata;
    logic signed [SAMPLE_W-1:0] rd_sample;

    logic [CNT_W-1:0]           max_clamped;
    logic [CNT_W-1:0]           capacity;
    logic                       full;
    logic [PTR_W-1:0]           ptr_drop;
    logic [CNT_W-1:0]           cnt_drop;
    logic [CNT_W:0]             rem_shift;
    logic [SUM_W-1:0]           quo_signed;
    logic                       out_free;
    logic                       in_accept;

    bfwa_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(r_req.sample),
        .i_raddr(r_ptr),
        .o_rdata(mem_rdata)
    );

    assign rd_sample   = mem_rdata;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    always_comb begin
        if (r_max < MAX_SIZE_MIN) begin
            max_clamped = MAX_SIZE_MIN;
        end else if (r_max > MAX_SIZE_MAX) begin
            max_clamped = MAX_SIZE_MAX;
        end else begin
            max_clamped = r_max;
        end
    end

    assign capacity  = max_clamped - CNT_W'(1);
    assign full      = (r_cnt >= capacity) && (r_cnt != '0);
    // oldest slot goes away first when full, the new sample lands behind the rest
    assign ptr_drop  = full ? r_ptr + PTR_W'(1) : r_ptr;
    assign cnt_drop  = full ? r_cnt - CNT_W'(1) : r_cnt;
    assign mem_waddr = ptr_drop + cnt_drop[PTR_W-1:0];
    assign mem_we    = (r_state == S_READ) && (r_req.command == CMD_PUSH);

    assign rem_shift  = {r_rem, r_quo[SUM_W-1]};
    assign quo_signed = r_neg ? -r_quo : r_quo;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_head    = r_head;
        n_head_ok = r_head_ok;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_step    = r_step;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                case (r_req.command)
                    CMD_PUSH: begin
                        n_ptr     = ptr_drop;
                        n_cnt     = cnt_drop + CNT_W'(1);
                        n_sum     = r_sum - (full ? SUM_W'(rd_sample) : '0)
                                    + SUM_W'(r_req.sample);
                        n_head_ok = 1'b1;
                    end
                    CMD_POP: begin
                        n_head    = rd_sample;
                        n_head_ok = (r_cnt != '0);
                        if (r_cnt != '0) begin
                            n_ptr = r_ptr + PTR_W'(1);
                            n_cnt = r_cnt - CNT_W'(1);
                            n_sum = r_sum - SUM_W'(rd_sample);
                        end
                    end
                    default: begin
                        n_head    = rd_sample;
                        n_head_ok = (r_cnt != '0);
                    end
                endcase
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // ring now holds the pushed sample, head reread at the new pointer
                if (r_req.command == CMD_PUSH) begin
                    n_head = rd_sample;
                end
                n_rem  = '0;
                n_step = '0;
                n_neg  = r_sum[SUM_W-1];
                n_quo  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                if (r_cnt == '0) begin
                    n_quo   = '0;
                    n_neg   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_shift >= {1'b0, r_cnt}) begin
                    n_rem = CNT_W'(rem_shift - {1'b0, r_cnt});
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_shift[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= MAX_SIZE_RESET;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_req;
        end
        r_head    <= n_head;
        r_head_ok <= n_head_ok;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_step    <= n_step;
        if (r_state == S_DONE && out_free) begin
            r_out.head_value    <= r_head_ok ? r_head : '0;
            r_out.head_valid    <= r_head_ok;
            r_out.count         <= r_cnt;
            r_out.average       <= quo_signed[SAMPLE_W-1:0];
            r_out.average_valid <= (r_cnt != '0);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RING_DEPTH))
        else $error("sample count above ring depth");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_READ))
        else $error("accepted request did not start the ring read");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider running with empty fifo");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_cnt))
        else $error("partial remainder not below divisor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result changed under stall");

endmodule

`default_nettype wire

// ===== src/bfwa_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module bfwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
